FILE: rtl/core/ewa_pkg.sv
package ewa_pkg;

    localparam int WORD_BYTES = 8;

    // command codes
    localparam logic [1:0] CMD_RD_U = 2'd0;
    localparam logic [1:0] CMD_RD_S = 2'd1;
    localparam logic [1:0] CMD_WR   = 2'd2;

    // byte orders
    localparam logic [1:0] ORD_LITTLE   = 2'd0;
    localparam logic [1:0] ORD_BIG      = 2'd1;
    localparam logic [1:0] ORD_PDP      = 2'd2;
    localparam logic [1:0] ORD_ANTI_PDP = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  byte_order;
        logic [3:0]  size_bytes;
        logic [3:0]  avail_bytes;
        logic [63:0] data_in;
        logic [63:0] value_in;
    } t_req;

    typedef struct packed {
        logic [7:0]  byte_enable;
        logic [63:0] bytes_out;
        logic [63:0] value_out;
    } t_rsp;

    // Memory byte idx -> word lane. Results outside 0..size-1 mean the byte
    // has no home in the word.
    function automatic logic signed [5:0] lane_map(
        input logic [1:0] order,
        input logic [3:0] size,
        input logic [3:0] idx
    );
        logic signed [5:0] s;
        logic signed [5:0] x;
        logic signed [5:0] sw;
        s  = signed'({2'b00, size});
        x  = signed'({2'b00, idx});
        sw = x ^ 6'sd1;
        case (order)
            ORD_LITTLE: lane_map = x;
            ORD_BIG:    lane_map = s - x - 6'sd1;
            ORD_PDP:    lane_map = (size > 4'd1) ? (s - sw - 6'sd1) : x;
            default:    lane_map = (size > 4'd1) ? sw : x;
        endcase
    endfunction

    // Word lane -> source memory byte, the inverse of lane_map. Only the
    // PDP-11 order with an odd size differs from lane_map itself. A result
    // at or above the byte count means the lane has no source.
    function automatic logic signed [5:0] lane_src(
        input logic [1:0] order,
        input logic [3:0] size,
        input logic [3:0] lane
    );
        logic signed [5:0] s;
        logic signed [5:0] x;
        s = signed'({2'b00, size});
        x = signed'({2'b00, lane});
        case (order)
            ORD_PDP: lane_src = (size > 4'd1) ? ((s - x - 6'sd1) ^ 6'sd1) : x;
            default: lane_src = lane_map(order, size, lane);
        endcase
    endfunction

endpackage

FILE: rtl/core/ewa_align.sv
module ewa_align
    import ewa_pkg::*;
#(
    parameter int MAX_BYTES = 8
) (
    input  t_req i_req,
    output t_rsp o_rsp
);

    logic [3:0]       size_eff;
    logic [3:0]       avail_eff;
    logic [7:0]       data_lane  [WORD_BYTES];
    logic [7:0]       value_lane [WORD_BYTES];
    logic [7:0]       rd_lane    [WORD_BYTES];
    logic [2:0]       sign_lane;
    logic             sign_bit;
    logic             do_ext;
    logic             is_rd;
    logic             is_wr;
    logic [63:0]      rd_word;
    logic [63:0]      wr_word;
    logic [7:0]       wr_be;

    assign size_eff  = (i_req.size_bytes > 4'(MAX_BYTES)) ? 4'(MAX_BYTES) : i_req.size_bytes;
    assign avail_eff = (i_req.avail_bytes > size_eff) ? size_eff : i_req.avail_bytes;
    assign is_rd     = (i_req.cmd == CMD_RD_U) || (i_req.cmd == CMD_RD_S);
    assign is_wr     = (i_req.cmd == CMD_WR);

    always_comb begin
        for (int k = 0; k < WORD_BYTES; k++) begin
            data_lane[k]  = i_req.data_in[8*k +: 8];
            value_lane[k] = i_req.value_in[8*k +: 8];
        end
    end

    // read: each lane pulls from its source memory byte
    always_comb begin
        logic signed [5:0] src;
        for (int l = 0; l < WORD_BYTES; l++) begin
            src = lane_src(i_req.byte_order, size_eff, 4'(l));
            rd_lane[l] = 8'h00;
            if ((4'(l) < size_eff) && (src >= 6'sd0) && (src < signed'({2'b00, avail_eff})))
                rd_lane[l] = data_lane[src[2:0]];
        end
    end

    assign sign_lane = 3'(size_eff - 4'd1);
    assign sign_bit  = rd_lane[sign_lane][7];
    assign do_ext    = (i_req.cmd == CMD_RD_S) && (size_eff != 4'd0)
                       && (size_eff < 4'(WORD_BYTES)) && sign_bit;

    always_comb begin
        for (int l = 0; l < WORD_BYTES; l++) begin
            if (do_ext && (4'(l) >= size_eff))
                rd_word[8*l +: 8] = 8'hFF;
            else
                rd_word[8*l +: 8] = rd_lane[l];
        end
    end

    // write: each present memory byte takes its value lane
    always_comb begin
        logic signed [5:0] off;
        for (int i = 0; i < WORD_BYTES; i++) begin
            off = lane_map(i_req.byte_order, size_eff, 4'(i));
            wr_word[8*i +: 8] = 8'h00;
            wr_be[i]          = 1'b0;
            if ((4'(i) < avail_eff) && (off >= 6'sd0) && (off < signed'({2'b00, size_eff})))
            begin
                wr_word[8*i +: 8] = value_lane[off[2:0]];
                wr_be[i]          = 1'b1;
            end
        end
    end

    assign o_rsp.value_out   = is_rd ? rd_word : 64'd0;
    assign o_rsp.bytes_out   = is_wr ? wr_word : 64'd0;
    assign o_rsp.byte_enable = is_wr ? wr_be : 8'd0;

endmodule

FILE: rtl/core/endian_word_access_unit.sv
// Byte-lane alignment for loads and stores in little, big, PDP-11 and
// anti-PDP-11 byte order, word sizes 1..MAX_BYTES bytes.
// Slave channel s_axis: one access per transfer. tuser carries the command
// (read unsigned, read signed, write) and the byte order; tdata carries
// size, available byte count, the memory bytes and the value to store.
// Master channel m_axis: one result per access, the assembled (zero or
// sign extended) read value, the written memory bytes and byte enables.
// The input transfer is loaded into the input register; the result
// register, loaded from the lane muxes, drives m_axis.
// Throughput: one access per cycle while m_axis_tready is high; each
// register reloads in the cycle it is drained, and the lane muxes are
// combinational between the registers.
// s_axis_tready stays high while the input register is empty or can move
// on, so a stalled receiver backs up at most two accesses before
// tready drops. Nothing is lost or repeated under stall.
// Reset (i_rst_n low, synchronous) empties both registers; no other state.
module endian_word_access_unit
    import ewa_pkg::*;
#(
    parameter int MAX_BYTES = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [3:0] size_bytes, [7:4] avail_bytes, [71:8] data_in, [135:72] value_in
    input  logic [135:0] s_axis_tdata,
    // [1:0] cmd, [3:2] byte_order
    input  logic [3:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] value_out, [127:64] bytes_out, [135:128] byte_enable
    output logic [135:0] m_axis_tdata
);

    t_req r_req;
    t_req n_req;
    logic r_req_vld;
    t_rsp r_rsp;
    t_rsp rsp;
    logic r_rsp_vld;
    logic out_adv;
    logic in_adv;

    assign out_adv       = !r_rsp_vld || m_axis_tready;
    assign in_adv        = !r_req_vld || out_adv;
    assign s_axis_tready = in_adv;

    assign n_req.cmd         = s_axis_tuser[1:0];
    assign n_req.byte_order  = s_axis_tuser[3:2];
    assign n_req.size_bytes  = s_axis_tdata[3:0];
    assign n_req.avail_bytes = s_axis_tdata[7:4];
    assign n_req.data_in     = s_axis_tdata[71:8];
    assign n_req.value_in    = s_axis_tdata[135:72];

    ewa_align #(
        .MAX_BYTES(MAX_BYTES)
    ) u_align (
        .i_req(r_req),
        .o_rsp(rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_rsp_vld <= 1'b0;
        end else begin
            if (in_adv)
                r_req_vld <= s_axis_tvalid;
            if (out_adv)
                r_rsp_vld <= r_req_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && s_axis_tvalid)
            r_req <= n_req;
        if (out_adv && r_req_vld)
            r_rsp <= rsp;
    end

    assign m_axis_tvalid = r_rsp_vld;
    assign m_axis_tdata  = {r_rsp.byte_enable, r_rsp.bytes_out, r_rsp.value_out};

endmodule
